>>> rtl/core/erbd_pkg.sv
// types and constants shared by the escape run-length block decoder
`timescale 1ns / 1ps
`default_nettype none

package erbd_pkg;

	localparam logic [7:0] ESC_BYTE  = 8'hED;
	localparam logic [7:0] TERM_BYTE = 8'h00;

	localparam logic [17:0] WIN_LOW = 18'h04000;
	localparam logic [17:0] WIN_END = 18'h10000;

	localparam logic [15:0] DEST_BASE_RST  = 16'h4000;
	localparam logic [16:0] DEST_LIMIT_RST = 17'd49152;
	localparam logic        ALLOW_TERM_RST = 1'b1;

	localparam int NUM_SLOTS = 5;
	localparam int DONE_SLOT = 4;

	localparam logic [1:0] CFG_DEST_BASE  = 2'd0;
	localparam logic [1:0] CFG_DEST_LIMIT = 2'd1;
	localparam logic [1:0] CFG_ALLOW_TERM = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] write_address;
		logic [7:0]  write_value;
		logic [7:0]  repeat_count;
		logic        block_done;
		logic [15:0] bytes_consumed;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [16:0] value;
	} cfg_req_t;

endpackage

`default_nettype wire

>>> rtl/core/erbd_stream_if.sv
// valid/ready channel carrying one request payload
`timescale 1ns / 1ps
`default_nettype none

interface erbd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/escape_rle_block_decoder.sv
// escape run-length block decoder: lookahead window, run clipping, result buffer
// latency: results of an accepted byte are presented from the next cycle on
// throughput: one byte per cycle while each byte yields at most one result and the result port is ready
// a byte yielding several results (up to five) holds the input until the single result port
// takes the last of them from the five-slot result buffer
// reset: lookahead count, counters and pending results cleared; configuration registers return to defaults
`timescale 1ns / 1ps
`default_nettype none

module escape_rle_block_decoder
	import erbd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	erbd_stream_if.sink             cdata,
	erbd_stream_if.source           wrun,
	erbd_stream_if.sink             cfg
);

	// configuration
	logic [15:0] base_q;
	logic [16:0] lim_q;
	logic        term_en_q;

	// decode state
	logic [7:0]  lb_q [3];
	logic [1:0]  lc_q;
	logic [16:0] oc_q;
	logic [15:0] cc_q;
	logic        swal_q;

	// result buffer
	out_item_t   res_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] pend_q;

	logic        acc;
	logic        out_fire;
	logic [7:0]  b;
	logic        fin;
	logic [7:0]  w [4];
	logic        full;
	logic        at_limit;
	logic [16:0] room;
	logic        is_term;
	logic        is_run;
	logic [2:0]  lit_len;
	logic [2:0]  lit_take;
	logic [17:0] a0;
	logic [7:0]  run_len;
	logic [17:0] a1;
	logic [17:0] lo;
	logic [17:0] hi;
	logic        run_ok;
	logic        run_done;
	logic [17:0] lit_addr [4];

	out_item_t   slot [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] slot_v;
	logic [15:0] done_cons;
	logic        nx_done;
	logic [1:0]  nx_lc;
	logic [16:0] nx_oc;
	logic [15:0] nx_cc;
	logic        nx_swal;
	logic        shift_lb;
	logic        push_lb;

	logic [2:0]  sel_idx;
	logic [NUM_SLOTS-1:0] sel_oh;

	assign acc      = cdata.valid && cdata.ready;
	assign out_fire = wrun.valid && wrun.ready;
	assign b        = cdata.data.data_byte;
	assign fin      = cdata.data.final_byte;

	assign cdata.ready = (pend_q == '0) || ($onehot(pend_q) && wrun.ready);
	assign cfg.ready   = 1'b1;

	// lookahead window
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < lc_q) begin
				w[i] = lb_q[i];
			end else begin
				w[i] = b;
			end
		end
		w[3] = b;
	end

	assign full     = lc_q == 2'd3;
	assign at_limit = oc_q >= lim_q;
	assign room     = lim_q - oc_q;
	assign is_term  = full && term_en_q && w[0] == TERM_BYTE && w[1] == ESC_BYTE
		&& w[2] == ESC_BYTE && w[3] == TERM_BYTE;
	assign is_run   = full && w[0] == ESC_BYTE && w[1] == ESC_BYTE;

	assign lit_len  = fin ? ({1'b0, lc_q} + 3'd1) : (full ? 3'd1 : 3'd0);
	assign lit_take = ({14'd0, lit_len} > room) ? room[2:0] : lit_len;

	// run clipping against limit and memory window
	assign a0       = {2'b0, base_q} + {1'b0, oc_q};
	assign run_len  = ({9'd0, w[2]} < room) ? w[2] : room[7:0];
	assign a1       = a0 + {10'd0, run_len};
	assign lo       = (a0 > WIN_LOW) ? a0 : WIN_LOW;
	assign hi       = (a1 < WIN_END) ? a1 : WIN_END;
	assign run_ok   = hi > lo;
	assign run_done = fin || ({9'd0, w[2]} >= room);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lit_addr[i] = a0 + 18'(i);
		end
	end

	// decode step
	always_comb begin
		slot_v    = '0;
		for (int i = 0; i < 4; i++) begin
			slot[i] = '{write_address: lit_addr[i][15:0], write_value: w[i],
				repeat_count: 8'd1, block_done: 1'b0, bytes_consumed: 16'd0};
		end
		done_cons = cc_q;
		nx_done   = 1'b0;
		nx_lc     = lc_q;
		nx_oc     = oc_q;
		nx_cc     = cc_q;
		nx_swal   = swal_q;
		shift_lb  = 1'b0;
		push_lb   = 1'b0;

		if (swal_q) begin
			nx_swal = !fin;
		end else if (at_limit) begin
			nx_done = 1'b1;
		end else if (is_term) begin
			nx_done   = 1'b1;
			done_cons = cc_q + 16'd4;
		end else if (is_run) begin
			slot[0]   = '{write_address: lo[15:0], write_value: w[3],
				repeat_count: 8'(hi - lo), block_done: 1'b0, bytes_consumed: 16'd0};
			slot_v[0] = run_ok;
			done_cons = cc_q + 16'd4;
			if (run_done) begin
				nx_done = 1'b1;
			end else begin
				nx_oc = oc_q + {9'd0, run_len};
				nx_cc = cc_q + 16'd4;
				nx_lc = 2'd0;
			end
		end else if (lit_len != 3'd0) begin
			for (int i = 0; i < 4; i++) begin
				slot_v[i] = (3'(i) < lit_take) && lit_addr[i] >= WIN_LOW
					&& lit_addr[i] < WIN_END;
			end
			done_cons = cc_q + {13'd0, lit_take};
			if (fin || {14'd0, lit_len} >= room) begin
				nx_done = 1'b1;
			end else begin
				nx_oc    = oc_q + 17'd1;
				nx_cc    = cc_q + 16'd1;
				shift_lb = 1'b1;
			end
		end else begin
			push_lb = 1'b1;
			nx_lc   = lc_q + 2'd1;
		end

		slot[DONE_SLOT] = '{write_address: 16'd0, write_value: 8'd0,
			repeat_count: 8'd0, block_done: 1'b1, bytes_consumed: done_cons};
		slot_v[DONE_SLOT] = nx_done;

		if (nx_done) begin
			nx_lc   = 2'd0;
			nx_oc   = '0;
			nx_cc   = '0;
			nx_swal = !fin;
		end
	end

	// lowest pending slot goes out first
	assign sel_oh = pend_q & (~pend_q + 5'd1);

	always_comb begin
		sel_idx = 3'd0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel_idx = 3'(i);
			end
		end
	end

	assign wrun.valid = pend_q != '0;
	assign wrun.data  = res_q[sel_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= DEST_BASE_RST;
			lim_q     <= DEST_LIMIT_RST;
			term_en_q <= ALLOW_TERM_RST;
			lc_q      <= 2'd0;
			oc_q      <= '0;
			cc_q      <= '0;
			swal_q    <= 1'b0;
			pend_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					CFG_DEST_BASE:  base_q    <= cfg.data.value[15:0];
					CFG_DEST_LIMIT: lim_q     <= cfg.data.value;
					CFG_ALLOW_TERM: term_en_q <= cfg.data.value[0];
					default: ;
				endcase
			end
			if (acc) begin
				lc_q   <= nx_lc;
				oc_q   <= nx_oc;
				cc_q   <= nx_cc;
				swal_q <= nx_swal;
				pend_q <= slot_v;
			end else if (out_fire) begin
				pend_q <= pend_q & ~sel_oh;
			end
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				res_q[i] <= slot[i];
			end
			if (shift_lb) begin
				lb_q[0] <= w[1];
				lb_q[1] <= w[2];
				lb_q[2] <= w[3];
			end else if (push_lb) begin
				lb_q[lc_q] <= b;
			end
		end
	end

	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cdata.ready |-> $countones(pend_q) <= 1)
		else $error("input taken with several results pending");

	a_swallow_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && swal_q |=> pend_q == '0)
		else $error("swallowed byte produced a result");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		wrun.valid && wrun.data.block_done |-> $onehot(pend_q))
		else $error("done result sent ahead of pending writes");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && slot_v[DONE_SLOT] |=> oc_q == '0 && cc_q == '0 && lc_q == 2'd0)
		else $error("block end left counters set");

	a_lookahead_full: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !swal_q && !at_limit && !fin && full && !is_term && !slot_v[DONE_SLOT]
		|=> lc_q == 2'd3 || lc_q == 2'd0)
		else $error("lookahead count lost on full window");

endmodule

`default_nettype wire
